[rtl/linear_float_to_srgb8_pixel_core_defines.svh]
// Assertion macros shared by the pixel converter's checker.
`ifndef LINEAR_FLOAT_TO_SRGB8_PIXEL_CORE_DEFINES_SVH
`define LINEAR_FLOAT_TO_SRGB8_PIXEL_CORE_DEFINES_SVH

// Checked on every rising clock edge, skipped while reset is asserted.
`define LF2S_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define LF2S_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[rtl/lf2s_pkg.sv]
// Types, constants and the sRGB lookup table of the pixel converter.
package lf2s_pkg;

  localparam logic [31:0] LowBits  = 32'h3900_0000;
  localparam logic [31:0] HighBits = 32'h3f7f_ffff;
  localparam logic [31:0] PosInf   = 32'h7f80_0000;
  localparam int unsigned RomDepth = 104;
  localparam logic [6:0]  RomLast  = 7'(RomDepth - 1);
  localparam logic [7:0]  AlphaScale  = 8'hff;
  localparam logic [7:0]  AlphaExpOfs = 8'd110;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } lf2s_en_t;

  // Each word holds the segment bias in the upper half and the slope in the lower half.
  localparam logic [31:0] SrgbRom [RomDepth] = '{
    32'h0073000d, 32'h007a000d, 32'h0080000d, 32'h0087000d,
    32'h008d000d, 32'h0094000d, 32'h009a000d, 32'h00a1000d,
    32'h00a7001a, 32'h00b4001a, 32'h00c1001a, 32'h00ce001a,
    32'h00da001a, 32'h00e7001a, 32'h00f4001a, 32'h0101001a,
    32'h010e0033, 32'h01280033, 32'h01410033, 32'h015b0033,
    32'h01750033, 32'h018f0033, 32'h01a80033, 32'h01c20033,
    32'h01dc0067, 32'h020f0067, 32'h02430067, 32'h02760067,
    32'h02aa0067, 32'h02dd0067, 32'h03110067, 32'h03440067,
    32'h037800ce, 32'h03df00ce, 32'h044600ce, 32'h04ad00ce,
    32'h051400ce, 32'h057b00c5, 32'h05dd00bc, 32'h063b00b5,
    32'h06970158, 32'h07420142, 32'h07e30130, 32'h087b0120,
    32'h090b0112, 32'h09940106, 32'h0a1700fc, 32'h0a9500f2,
    32'h0b0f01cb, 32'h0bf401ae, 32'h0ccb0195, 32'h0d950180,
    32'h0e56016e, 32'h0f0d015e, 32'h0fbc0150, 32'h10630143,
    32'h11070264, 32'h1238023e, 32'h1357021d, 32'h14660201,
    32'h156601e9, 32'h165a01d3, 32'h174401c0, 32'h182401af,
    32'h18fe0331, 32'h1a9602fe, 32'h1c1502d2, 32'h1d7e02ad,
    32'h1ed4028d, 32'h201a0270, 32'h21520256, 32'h227d0240,
    32'h239f0443, 32'h25c003fe, 32'h27bf03c4, 32'h29a10392,
    32'h2b6a0367, 32'h2d1d0341, 32'h2ebe031f, 32'h304d0300,
    32'h31d105b0, 32'h34a80555, 32'h37520507, 32'h39d504c5,
    32'h3c37048b, 32'h3e7c0458, 32'h40a8042a, 32'h42bd0401,
    32'h44c20798, 32'h488e071e, 32'h4c1c06b6, 32'h4f76065d,
    32'h52a50610, 32'h55ac05cc, 32'h5892058f, 32'h5b590559,
    32'h5e0c0a23, 32'h631c0980, 32'h67db08f6, 32'h6c55087f,
    32'h70940818, 32'h74a007bd, 32'h787d076c, 32'h7c330723
  };

  // Negative values, zero, NaN and tiny values go to the low end; large ones saturate.
  function automatic logic [31:0] lf2s_clamp(input logic [31:0] raw);
    logic [31:0] res;
    res = raw;
    if (raw[31] || (raw > PosInf) || (raw < LowBits)) begin
      res = LowBits;
    end else if (raw > HighBits) begin
      res = HighBits;
    end
    return res;
  endfunction

endpackage

[rtl/lf2s_color.sv]
// One color channel: table lookup and linear interpolation to an sRGB byte.
module lf2s_color
  import lf2s_pkg::*;
(
  input  logic        clk_i,
  input  lf2s_en_t    en_i,
  input  logic [31:0] raw_i,
  output logic [7:0]  byte_o
);

  logic [31:0] clamped;
  logic [31:0] offset;
  logic [6:0]  idx;
  logic [31:0] word;
  logic [15:0] bias_d, bias_q;
  logic [15:0] scale_d, scale_q;
  logic [7:0]  frac_d, frac_q;
  logic [23:0] prod;
  logic [25:0] sum_d, sum_q;
  logic [9:0]  sum_hi;
  logic [7:0]  byte_d, byte_q;
  logic [7:0]  dly_q, out_q;

  always_comb begin
    clamped = lf2s_clamp(raw_i);
    offset  = clamped - LowBits;
    idx     = (offset[26:20] > RomLast) ? RomLast : offset[26:20];
    word    = SrgbRom[idx];
    bias_d  = word[31:16];
    scale_d = word[15:0];
    frac_d  = clamped[19:12];
  end

  assign prod   = scale_q * frac_q;
  assign sum_d  = {1'b0, bias_q, 9'd0} + {2'b00, prod};
  assign sum_hi = sum_q[25:16];
  assign byte_d = (sum_hi[9:8] != 2'b00) ? 8'hff : sum_hi[7:0];

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      bias_q  <= bias_d;
      scale_q <= scale_d;
      frac_q  <= frac_d;
    end
    if (en_i.s2) begin
      sum_q <= sum_d;
    end
    if (en_i.s3) begin
      byte_q <= byte_d;
    end
    if (en_i.s4) begin
      dly_q <= byte_q;
    end
    if (en_i.s5) begin
      out_q <= dly_q;
    end
  end

  assign byte_o = out_q;

endmodule

[rtl/lf2s_alpha.sv]
// Alpha channel: A * 255 + 0.5 with single-precision rounding, in exact fixed point.
module lf2s_alpha
  import lf2s_pkg::*;
(
  input  logic        clk_i,
  input  lf2s_en_t    en_i,
  input  logic [31:0] raw_i,
  output logic [7:0]  byte_o
);

  logic [31:0] clamped;
  logic [7:0]  exp_q, exp2_q;
  logic [23:0] mant_q;
  logic [31:0] prod_d, prod_q;
  logic [23:0] base;
  logic        grd, stk;
  logic [24:0] rnd_d, rnd_q;
  logic [7:0]  sh_full;
  logic [4:0]  sh_q;
  logic [48:0] fix_d, fix_q;
  logic [5:0]  top;
  logic [4:0]  cut;
  logic [48:0] kept;
  logic [48:0] low_mask;
  logic        lsb_g, lsb_s, inc;
  logic [33:0] rounded;
  logic [33:0] scaled;
  logic [7:0]  byte_d, out_q;

  assign clamped = lf2s_clamp(raw_i);
  assign prod_d  = {8'd0, mant_q} * {24'd0, AlphaScale};

  // Round the product to 24 significant bits; it has 31 or 32 bits.
  always_comb begin
    if (prod_q[31]) begin
      base    = prod_q[31:8];
      grd     = prod_q[7];
      stk     = |prod_q[6:0];
      sh_full = exp2_q + 8'd8 - AlphaExpOfs;
    end else begin
      base    = prod_q[30:7];
      grd     = prod_q[6];
      stk     = |prod_q[5:0];
      sh_full = exp2_q + 8'd7 - AlphaExpOfs;
    end
    rnd_d = {1'b0, base} + {24'd0, grd & (stk | base[0])};
  end

  // Aligned to 40 fraction bits, with the half added.
  assign fix_d = ({24'd0, rnd_q} << sh_q) + (49'd1 << 39);

  // The sum is at least one half, so its leading one sits in bits 48 down to 39.
  always_comb begin
    top = 6'd39;
    for (int i = 39; i < 49; i++) begin
      if (fix_q[i]) begin
        top = 6'(i);
      end
    end
    cut      = 5'(top - 6'd23);
    kept     = fix_q >> cut;
    low_mask = (49'd1 << (cut - 5'd1)) - 49'd1;
    lsb_g    = fix_q[cut - 5'd1];
    lsb_s    = |(fix_q & low_mask);
    inc      = lsb_g & (lsb_s | kept[0]);
    rounded  = kept[33:0] + {33'd0, inc};
    scaled   = rounded >> (6'd63 - top);
    byte_d   = (scaled[33:8] != '0) ? 8'hff : scaled[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      exp_q  <= clamped[30:23];
      mant_q <= {1'b1, clamped[22:0]};
    end
    if (en_i.s2) begin
      prod_q <= prod_d;
      exp2_q <= exp_q;
    end
    if (en_i.s3) begin
      rnd_q <= rnd_d;
      sh_q  <= sh_full[4:0];
    end
    if (en_i.s4) begin
      fix_q <= fix_d;
    end
    if (en_i.s5) begin
      out_q <= byte_d;
    end
  end

  assign byte_o = out_q;

endmodule

[rtl/linear_float_to_srgb8_pixel_core.sv]
// Linear float RGBA to 8-bit sRGB BGRA pixel converter, top level.
// Throughput is one pixel per cycle; each of the five stages holds its item under
// back-pressure and fills from the stage before as soon as it is free.
// Reset clears the stage valid bits only; the datapath registers are not reset.
module linear_float_to_srgb8_pixel_core
  import lf2s_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,  // red_in, green_in, blue_in, alpha_in
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [31:0]  m_axis_tdata_o   // blue_out, green_out, red_out, alpha_out
);

  logic [4:0] vld_q;
  logic [4:0] vld_d;
  lf2s_en_t   en;
  logic [7:0] red_b, green_b, blue_b, alpha_b;

  // A stage loads when it is empty or its content moves on in the same cycle.
  always_comb begin
    en.s5 = !vld_q[4] || m_axis_tready_i;
    en.s4 = !vld_q[3] || en.s5;
    en.s3 = !vld_q[2] || en.s4;
    en.s2 = !vld_q[1] || en.s3;
    en.s1 = !vld_q[0] || en.s2;
    vld_d[0] = en.s1 ? s_axis_tvalid_i : vld_q[0];
    vld_d[1] = en.s2 ? vld_q[0] : vld_q[1];
    vld_d[2] = en.s3 ? vld_q[1] : vld_q[2];
    vld_d[3] = en.s4 ? vld_q[2] : vld_q[3];
    vld_d[4] = en.s5 ? vld_q[3] : vld_q[4];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  lf2s_color u_red (
    .clk_i  (clk_i),
    .en_i   (en),
    .raw_i  (s_axis_tdata_i[31:0]),
    .byte_o (red_b)
  );

  lf2s_color u_green (
    .clk_i  (clk_i),
    .en_i   (en),
    .raw_i  (s_axis_tdata_i[63:32]),
    .byte_o (green_b)
  );

  lf2s_color u_blue (
    .clk_i  (clk_i),
    .en_i   (en),
    .raw_i  (s_axis_tdata_i[95:64]),
    .byte_o (blue_b)
  );

  lf2s_alpha u_alpha (
    .clk_i  (clk_i),
    .en_i   (en),
    .raw_i  (s_axis_tdata_i[127:96]),
    .byte_o (alpha_b)
  );

  assign s_axis_tready_o = en.s1;
  assign m_axis_tvalid_o = vld_q[4];
  assign m_axis_tdata_o  = {alpha_b, red_b, green_b, blue_b};

endmodule

[rtl/lf2s_checker.sv]
// Port-level checker for the pixel converter, bound to the top level.
`include "linear_float_to_srgb8_pixel_core_defines.svh"

module lf2s_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [31:0]  m_axis_tdata_o
);

  // No result may appear while reset is held.
  `LF2S_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !m_axis_tvalid_o, "result during reset")

  // A result that is not taken stays unchanged.
  `LF2S_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")

  // An empty output stage means the whole pipeline can take a request.
  `LF2S_ASSERT(a_ready_when_drained, !m_axis_tvalid_o |-> s_axis_tready_o, "not ready with empty output")

  // Back-pressure on the input only comes from a stalled result.
  `LF2S_ASSERT(a_stall_source, !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i, "input stalled without output stall")

endmodule

bind linear_float_to_srgb8_pixel_core lf2s_checker u_lf2s_checker (.*);

[test/linear_float_to_srgb8_pixel_core_tb.sv]
// Self-checking testbench of the linear float to sRGB8 pixel converter.
`timescale 1ns / 1ps

module linear_float_to_srgb8_pixel_core_tb;
  import lf2s_pkg::*;

  // Field order from the lowest bit up: red, green, blue, alpha.
  typedef struct packed {
    logic [31:0] alpha;
    logic [31:0] blue;
    logic [31:0] green;
    logic [31:0] red;
  } rgba_f32_t;

  // Field order from the lowest bit up: blue, green, red, alpha.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bgra8_t;

  localparam int unsigned RandomPixels = 1930;
  localparam int unsigned SegmentLen   = 64;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned DrainCycles  = 20;

  localparam logic [31:0] srgb_segments [104] = '{
    32'h0073000d, 32'h007a000d, 32'h0080000d, 32'h0087000d,
    32'h008d000d, 32'h0094000d, 32'h009a000d, 32'h00a1000d,
    32'h00a7001a, 32'h00b4001a, 32'h00c1001a, 32'h00ce001a,
    32'h00da001a, 32'h00e7001a, 32'h00f4001a, 32'h0101001a,
    32'h010e0033, 32'h01280033, 32'h01410033, 32'h015b0033,
    32'h01750033, 32'h018f0033, 32'h01a80033, 32'h01c20033,
    32'h01dc0067, 32'h020f0067, 32'h02430067, 32'h02760067,
    32'h02aa0067, 32'h02dd0067, 32'h03110067, 32'h03440067,
    32'h037800ce, 32'h03df00ce, 32'h044600ce, 32'h04ad00ce,
    32'h051400ce, 32'h057b00c5, 32'h05dd00bc, 32'h063b00b5,
    32'h06970158, 32'h07420142, 32'h07e30130, 32'h087b0120,
    32'h090b0112, 32'h09940106, 32'h0a1700fc, 32'h0a9500f2,
    32'h0b0f01cb, 32'h0bf401ae, 32'h0ccb0195, 32'h0d950180,
    32'h0e56016e, 32'h0f0d015e, 32'h0fbc0150, 32'h10630143,
    32'h11070264, 32'h1238023e, 32'h1357021d, 32'h14660201,
    32'h156601e9, 32'h165a01d3, 32'h174401c0, 32'h182401af,
    32'h18fe0331, 32'h1a9602fe, 32'h1c1502d2, 32'h1d7e02ad,
    32'h1ed4028d, 32'h201a0270, 32'h21520256, 32'h227d0240,
    32'h239f0443, 32'h25c003fe, 32'h27bf03c4, 32'h29a10392,
    32'h2b6a0367, 32'h2d1d0341, 32'h2ebe031f, 32'h304d0300,
    32'h31d105b0, 32'h34a80555, 32'h37520507, 32'h39d504c5,
    32'h3c37048b, 32'h3e7c0458, 32'h40a8042a, 32'h42bd0401,
    32'h44c20798, 32'h488e071e, 32'h4c1c06b6, 32'h4f76065d,
    32'h52a50610, 32'h55ac05cc, 32'h5892058f, 32'h5b590559,
    32'h5e0c0a23, 32'h631c0980, 32'h67db08f6, 32'h6c55087f,
    32'h70940818, 32'h74a007bd, 32'h787d076c, 32'h7c330723
  };

  // Zeros, infinities, NaNs, denormals and both ends of the clamp window.
  localparam int unsigned NumCorners = 20;
  localparam logic [31:0] corner_vals [NumCorners] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
    32'h7fc0_0000, 32'hffc0_0000, 32'h7f80_0001, 32'h7fff_ffff,
    32'h38ff_ffff, 32'h3900_0000, 32'h3900_0001, 32'h3f7f_fffe,
    32'h3f7f_ffff, 32'h3f80_0000, 32'h3f00_0000, 32'h4000_0000,
    32'h7f7f_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h8000_0001
  };

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid_i = 1'b0;
  logic [127:0] s_axis_tdata_i = '0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [31:0]  m_axis_tdata_o;

  int unsigned hold_req = 0;
  bit          rx_idle_on = 1'b0;

  function automatic logic [31:0] clamp_channel(input logic [31:0] raw);
    if (raw[31]) return LowBits;
    if (raw > PosInf) return LowBits;
    if (raw < LowBits) return LowBits;
    if (raw > HighBits) return HighBits;
    return raw;
  endfunction

  function automatic logic [7:0] encode_srgb(input logic [31:0] raw);
    logic [31:0] c;
    logic [31:0] offs;
    logic [6:0]  idx;
    logic [7:0]  t;
    logic [31:0] word;
    logic [31:0] v;
    c = clamp_channel(raw);
    offs = c - LowBits;
    idx = offs[26:20];
    if (idx > 7'd103) idx = 7'd103;
    t = c[19:12];
    word = srgb_segments[idx];
    v = ((32'(word[31:16]) << 9) + 32'(word[15:0]) * 32'(t)) >> 16;
    return (v > 32'd255) ? 8'hff : v[7:0];
  endfunction

  function automatic int unsigned msb_count(input logic [63:0] v);
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) return i + 1;
    end
    return 0;
  endfunction

  // Right shift by d (1..63) rounding to nearest, ties to even.
  function automatic logic [63:0] shr_nearest_even(input logic [63:0] v, input int unsigned d);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    q = v >> d;
    rem = v & ((64'd1 << d) - 64'd1);
    half = 64'd1 << (d - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    return q;
  endfunction

  // Keeps 24 significant bits, as a single-precision result would.
  function automatic logic [63:0] keep_24_bits(input logic [63:0] v);
    int unsigned len;
    int unsigned d;
    len = msb_count(v);
    if (len <= 24) return v;
    d = len - 24;
    return shr_nearest_even(v, d) << d;
  endfunction

  function automatic logic [7:0] scale_alpha(input logic [31:0] raw);
    logic [31:0] c;
    int unsigned e;
    logic [63:0] m;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] y;
    int unsigned len;
    int unsigned d;
    int          sh;
    c = clamp_channel(raw);
    e = c[30:23];
    m = {40'd0, 1'b1, c[22:0]};
    p = m * 64'd255;
    len = msb_count(p);
    d = (len > 24) ? len - 24 : 0;
    q = (d != 0) ? shr_nearest_even(p, d) : p;
    // Align the rounded product to 40 fraction bits, then add one half.
    sh = int'(e) + int'(d) - 110;
    if (e < 110 || sh > 30) sh = 30;
    y = (q << sh) + (64'd1 << 39);
    y = keep_24_bits(y) >> 40;
    return (y > 64'd255) ? 8'hff : y[7:0];
  endfunction

  function automatic bgra8_t convert_pixel(input rgba_f32_t px);
    bgra8_t res;
    res.blue  = encode_srgb(px.blue);
    res.green = encode_srgb(px.green);
    res.red   = encode_srgb(px.red);
    res.alpha = scale_alpha(px.alpha);
    return res;
  endfunction

  class pixel_scoreboard;
    bgra8_t      pending_q[$];
    int unsigned errors = 0;
    int unsigned checked = 0;
    int unsigned low_clamps = 0;
    int unsigned high_clamps = 0;

    function void note_request(rgba_f32_t px);
      logic [31:0] ch[4];
      ch = '{px.red, px.green, px.blue, px.alpha};
      foreach (ch[i]) begin
        if (clamp_channel(ch[i]) == LowBits) low_clamps++;
        if (clamp_channel(ch[i]) == HighBits) high_clamps++;
      end
      pending_q.push_back(convert_pixel(px));
    endfunction

    function void check_result(bgra8_t got);
      bgra8_t want;
      if (pending_q.size() == 0) begin
        $error("result 0x%08h arrived with no pixel outstanding", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.blue !== want.blue) begin
        $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("green_out: expected %0d, got %0d", want.green, got.green);
        errors++;
      end
      if (got.red !== want.red) begin
        $error("red_out: expected %0d, got %0d", want.red, got.red);
        errors++;
      end
      if (got.alpha !== want.alpha) begin
        $error("alpha_out: expected %0d, got %0d", want.alpha, got.alpha);
        errors++;
      end
    endfunction
  endclass

  pixel_scoreboard sb = new();

  linear_float_to_srgb8_pixel_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

  // Output side: checks every accepted result and stalls in bursts.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(bgra8_t'(m_axis_tdata_o));
      if (hold_req != 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left != 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] pick_channel();
    int unsigned kind;
    logic [31:0] base;
    kind = $urandom_range(0, 99);
    if (kind < 60) return $urandom_range(LowBits, HighBits);
    if (kind < 70) return {1'b0, 8'($urandom_range(114, 126)), 23'($urandom())};
    if (kind < 80) return $urandom();
    if (kind < 90) begin
      case ($urandom_range(0, 4))
        0: base = LowBits;
        1: base = HighBits;
        2: base = PosInf;
        3: base = 32'h0000_0000;
        default: base = 32'h8000_0000;
      endcase
      return base + $urandom_range(0, 8) - 32'd4;
    end
    return corner_vals[$urandom_range(0, NumCorners - 1)];
  endfunction

  // Holds the request until it is accepted; the caller decides about any gap after it.
  task automatic send_pixel(input rgba_f32_t px);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= px;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(px);
  endtask

  task automatic pause_input(input bit idle_on);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  initial begin
    rgba_f32_t   px;
    bit          tx_idle_on;
    bit          quiet;
    int unsigned sent;
    int unsigned seg;

    // The falling transition at time zero starts the asynchronous reset.
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every corner value lands on every channel once.
    rx_idle_on = 1'b1;
    for (int i = 0; i < NumCorners; i++) begin
      px.red   = corner_vals[i];
      px.green = corner_vals[(i + 3) % NumCorners];
      px.blue  = corner_vals[(i + 7) % NumCorners];
      px.alpha = corner_vals[(i + 11) % NumCorners];
      send_pixel(px);
      pause_input(1'b1);
    end

    sent = 0;
    seg = 0;
    while (sent < RandomPixels) begin
      quiet = (sent + 4 * SegmentLen >= RandomPixels);
      tx_idle_on = !quiet && ($urandom_range(0, 3) != 0);
      rx_idle_on = !quiet && ($urandom_range(0, 3) != 0);
      // One long output stall with the input kept busy fills the pipeline.
      if (seg == 4) begin
        tx_idle_on = 1'b0;
        hold_req = LongHold;
      end
      for (int k = 0; k < SegmentLen && sent < RandomPixels; k++) begin
        px.red   = pick_channel();
        px.green = pick_channel();
        px.blue  = pick_channel();
        px.alpha = pick_channel();
        send_pixel(px);
        sent++;
        pause_input(tx_idle_on);
      end
      seg++;
    end
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d pixels: %0d corner pixels and %0d random ones, with stalls on both sides.",
             sb.checked, NumCorners, sent);
    $display("Channels clamped to the low end: %0d, to the high end: %0d.",
             sb.low_clamps, sb.high_clamps);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/lf2s_pkg.sv
rtl/lf2s_color.sv
rtl/lf2s_alpha.sv
rtl/linear_float_to_srgb8_pixel_core.sv
rtl/lf2s_checker.sv
test/linear_float_to_srgb8_pixel_core_tb.sv
